// ----- rtl/sc2a_pkg.sv -----
// shared types, constants and key tables for the scancode to ascii fifo
// no dependencies; imported by the interfaces, sc2a_decode, the core and the testbench

package sc2a_pkg;

  localparam int FIFO_DEPTH_DEF = 128;
  localparam int KEY_COUNT      = 58;
  localparam int KEY_W          = 6;
  localparam int SCAN_W         = 8;
  localparam int CHAR_W         = 7;
  localparam int COUNT_W        = 7;
  localparam int COUNT_MAX      = 127;

  typedef logic [SCAN_W-1:0]  scancode_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [COUNT_W-1:0] count_t;

  // request modes
  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // special scancodes
  localparam scancode_t SC_PREFIX       = 8'hE0;
  localparam scancode_t SC_LSHIFT_MAKE  = 8'h2A;
  localparam scancode_t SC_RSHIFT_MAKE  = 8'h36;
  localparam scancode_t SC_LSHIFT_BREAK = 8'hAA;
  localparam scancode_t SC_RSHIFT_BREAK = 8'hB6;
  localparam int        SC_BREAK_BIT    = 7;

  typedef struct packed {
    logic  push;
    char_t ch;
  } push_req_t;

  localparam char_t PLAIN_MAP [KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam char_t SHIFT_MAP [KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // key must already be checked against KEY_COUNT
  function automatic char_t key_char(logic shifted, logic [KEY_W-1:0] key);
    char_t c;
    c = shifted ? SHIFT_MAP[key] : PLAIN_MAP[key];
    return c;
  endfunction

endpackage

// ----- rtl/sc2a_if.sv -----
// request and response channel interfaces (valid/ready with payload)
// depends on sc2a_pkg

interface sc2a_in_if import sc2a_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      mode;
  scancode_t scancode;

  modport source (output valid, output mode, output scancode, input ready);
  modport sink   (input valid, input mode, input scancode, output ready);
endinterface

interface sc2a_out_if import sc2a_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   char_valid;
  char_t  char_out;
  count_t chars_waiting;

  modport source (output valid, output char_valid, output char_out,
                  output chars_waiting, input ready);
  modport sink   (input valid, input char_valid, input char_out,
                  input chars_waiting, output ready);
endinterface

// ----- rtl/sc2a_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies

module sc2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sc2a_decode.sv -----
// scancode decoder: prefix and shift tracking, table lookup to a push request
// depends on sc2a_pkg

module sc2a_decode import sc2a_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  scancode_t scancode,
  output push_req_t push_req
);

  logic shift_held;
  logic prefix_seen;
  logic is_prefix;
  logic is_shift_make;
  logic is_shift_break;
  logic key_ok;
  char_t ch;

  assign is_prefix      = (scancode == SC_PREFIX);
  assign is_shift_make  = (scancode == SC_LSHIFT_MAKE) || (scancode == SC_RSHIFT_MAKE);
  assign is_shift_break = (scancode == SC_LSHIFT_BREAK) || (scancode == SC_RSHIFT_BREAK);
  assign key_ok = !scancode[SC_BREAK_BIT] &&
                  (scancode[SCAN_W-2:0] < (SCAN_W-1)'(KEY_COUNT));
  assign ch = key_char(shift_held, scancode[KEY_W-1:0]);

  always_comb begin
    push_req.ch   = ch;
    push_req.push = take && !is_prefix && !prefix_seen && !is_shift_make &&
                    key_ok && (ch != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      prefix_seen <= 1'b0;
    end else if (take) begin
      if (is_prefix) begin
        prefix_seen <= 1'b1;
      end else if (prefix_seen) begin
        prefix_seen <= 1'b0;
      end else if (is_shift_make) begin
        shift_held <= 1'b1;
      end else if (is_shift_break) begin
        shift_held <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/scancode_to_ascii_fifo_core.sv -----
// top level: keyboard scancode decoder feeding a ram based character fifo
// depends on sc2a_pkg, sc2a_if, sc2a_ram, sc2a_decode

// usage
//   req channel: each request is either a scancode byte (mode 0) or a read of
//   one character (mode 1). rsp channel: exactly one response per request,
//   in order, with char_valid/char_out (nonzero only for a read that found a
//   character) and chars_waiting, the fill level after that request,
//   saturated at 127.
// timing
//   a request accepted on req passes through the ram read stage, whose
//   registered ram output is consumed when that stage hands on its
//   request, and then the output register, from which its response is
//   offered on rsp. one request per cycle is taken while rsp.ready stays
//   high, since each stage hands on its request in the same cycle that it
//   takes a new one.
// stalls
//   when rsp.ready is low, one response waits in the output register and one
//   more in the ram read stage; after that req.ready drops until the
//   receiver takes a response. req.ready is never tied to an idle state.
// reset
//   rst (synchronous) clears pointers, fill level, shift and prefix flags
//   and both pipeline stages. the character ram is not cleared: an entry is
//   only read after it was written, so no clearing pass is needed.
// the fifo holds FIFO_DEPTH-1 characters; a character decoded while full is
// dropped, and a read on an empty fifo returns char_valid 0.

module scancode_to_ascii_fifo_core import sc2a_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  sc2a_in_if.sink    req,
  sc2a_out_if.source rsp
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = (PW > COUNT_W) ? PW : COUNT_W;

  typedef logic [PW-1:0] ptr_t;

  // fifo pointers and fill level
  ptr_t wr_ptr, wr_ptr_next;
  ptr_t rd_ptr, rd_ptr_next;
  ptr_t fill, fill_next;

  logic      accept;
  logic      pop;
  logic      push;
  logic      take_scan;
  push_req_t push_req;
  char_t     rdata;
  logic [CW-1:0] fill_ext;
  count_t    count_sat;

  // ram read stage
  logic   s1_valid;
  logic   s1_char_valid;
  count_t s1_count;
  logic   s1_adv;

  // output register
  logic   out_valid;
  logic   out_char_valid;
  char_t  out_char;
  count_t out_count;

  assign s1_adv    = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;
  assign take_scan = accept && (req.mode == MODE_SCAN);

  sc2a_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .take     (take_scan),
    .scancode (req.scancode),
    .push_req (push_req)
  );

  // push only on scancode requests, pop only on reads: never both at once,
  // so the ram never sees a read and write of the same entry in one cycle
  assign push = push_req.push && (fill != PW'(FIFO_DEPTH - 1));
  assign pop  = accept && (req.mode == MODE_READ) && (fill != '0);

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fill_next   = fill;
    if (push) begin
      wr_ptr_next = (wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      fill_next   = fill + 1'b1;
    end else if (pop) begin
      rd_ptr_next = (rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      fill_next   = fill - 1'b1;
    end
  end

  // level reported after this request, saturated for deep fifos
  assign fill_ext  = CW'(fill_next);
  assign count_sat = (fill_ext > CW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                 : fill_ext[COUNT_W-1:0];

  sc2a_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata (push_req.ch),
    .re    (pop),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  // ram read stage: holds while stalled, and no new read is issued then,
  // so the ram output stays put with it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_char_valid <= pop;
      s1_count      <= count_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_valid && s1_adv) begin
      out_char_valid <= s1_char_valid;
      out_char       <= s1_char_valid ? rdata : '0;
      out_count      <= s1_count;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.char_valid    = out_char_valid;
  assign rsp.char_out      = out_char;
  assign rsp.chars_waiting = out_count;

  // assertions
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    push |-> !pop)
    else $error("ram written and read in the same cycle");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wr_ptr == rd_ptr))
    else $error("fifo empty but pointers differ");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while pipeline is full");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request lost before read stage");

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for scancode_to_ascii_fifo_core: keyboard requests in,
// one response per request out, checked against an in-bench decoder and fifo model
// depends on sc2a_pkg, sc2a_if and the core rtl
`timescale 1ns / 1ps

module tb_top;
  import sc2a_pkg::*;

  localparam int FIFO_DEPTH  = FIFO_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  // one predicted response
  typedef struct {
    logic   char_valid;
    char_t  char_out;
    count_t chars_waiting;
  } key_response_t;

  // decoder and fifo model plus the queue of responses still owed by the core
  class keyboard_scoreboard;
    // us layout, scancode set 1, keys 0..57
    char_t lower_keys [KEY_COUNT] = '{
      7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
      7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79,
      7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73, 7'h64,
      7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b, 7'h27, 7'h60, 7'h00, 7'h5c,
      7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00,
      7'h2a, 7'h00, 7'h20
    };
    char_t upper_keys [KEY_COUNT] = '{
      7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28,
      7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59,
      7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53, 7'h44,
      7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a, 7'h22, 7'h7e, 7'h00, 7'h7c,
      7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00,
      7'h2a, 7'h00, 7'h20
    };

    int            depth;
    char_t         char_ring [];
    int unsigned   wr_slot;
    int unsigned   rd_slot;
    bit            shift_down;
    bit            skip_next;
    key_response_t owed [$];
    int            fails;

    function new(int fifo_depth);
      depth      = fifo_depth;
      char_ring  = new[fifo_depth];
      wr_slot    = 0;
      rd_slot    = 0;
      shift_down = 1'b0;
      skip_next  = 1'b0;
      fails      = 0;
    endfunction

    function int unsigned bump(int unsigned slot);
      return (slot + 1 >= depth) ? 0 : slot + 1;
    endfunction

    function void decode_byte(scancode_t sc);
      char_t c;
      if (sc == SC_PREFIX) begin
        skip_next = 1'b1;
      end else if (skip_next) begin
        skip_next = 1'b0;
      end else if (sc == SC_LSHIFT_MAKE || sc == SC_RSHIFT_MAKE) begin
        shift_down = 1'b1;
      end else if (sc == SC_LSHIFT_BREAK || sc == SC_RSHIFT_BREAK) begin
        shift_down = 1'b0;
      end else if (!sc[SC_BREAK_BIT] && sc < KEY_COUNT) begin
        c = shift_down ? upper_keys[sc] : lower_keys[sc];
        // full ring drops the character
        if (c != '0 && bump(wr_slot) != rd_slot) begin
          char_ring[wr_slot] = c;
          wr_slot = bump(wr_slot);
        end
      end
    endfunction

    // model one accepted request and queue the response it owes
    function void note_request(logic m, scancode_t sc);
      key_response_t r;
      int unsigned   fill;
      r.char_valid = 1'b0;
      r.char_out   = '0;
      if (m == MODE_SCAN) begin
        decode_byte(sc);
      end else if (wr_slot != rd_slot) begin
        r.char_valid = 1'b1;
        r.char_out   = char_ring[rd_slot];
        rd_slot      = bump(rd_slot);
      end
      fill = (wr_slot >= rd_slot) ? wr_slot - rd_slot : wr_slot + depth - rd_slot;
      r.chars_waiting = (fill > COUNT_MAX) ? count_t'(COUNT_MAX) : count_t'(fill);
      owed.push_back(r);
    endfunction

    function void check_response(logic cv, char_t co, count_t cw);
      key_response_t r;
      if (owed.size() == 0) begin
        $error("response with nothing outstanding: char_valid %0d char_out %0h", cv, co);
        fails++;
        return;
      end
      r = owed.pop_front();
      if (cv !== r.char_valid) begin
        $error("char_valid mismatch: expected %0d, actual %0d", r.char_valid, cv);
        fails++;
      end
      if (co !== r.char_out) begin
        $error("char_out mismatch: expected %0h, actual %0h", r.char_out, co);
        fails++;
      end
      if (cw !== r.chars_waiting) begin
        $error("chars_waiting mismatch: expected %0d, actual %0d", r.chars_waiting, cw);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;   // set during stretches where neither side adds random idle gaps

  sc2a_in_if  req_if ();
  sc2a_out_if rsp_if ();

  keyboard_scoreboard sb;

  scancode_to_ascii_fifo_core #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // scancode mix that looks like typing: make and break codes, shifts, prefixed
  // codes, plus raw bytes so every value and bit shows up
  function automatic scancode_t pick_scancode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return scancode_t'($urandom_range(KEY_COUNT - 1));
    if (r < 68) return scancode_t'($urandom_range(KEY_COUNT - 1)) | 8'h80;
    if (r < 74) return $urandom_range(1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
    if (r < 80) return $urandom_range(1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK;
    if (r < 86) return SC_PREFIX;
    return scancode_t'($urandom_range(255));
  endfunction

  // offer one request; valid stays high between back-to-back requests
  task automatic send_request(input logic m, input scancode_t sc);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= m;
    req_if.scancode <= sc;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(m, sc);
  endtask

  task automatic send_scan(input scancode_t sc);
    send_request(MODE_SCAN, sc);
  endtask

  // read requests carry a random scancode, which the core must ignore
  task automatic send_read();
    send_request(MODE_READ, scancode_t'($urandom_range(255)));
  endtask

  task automatic run_phase(input int n, input int read_pct, input bit quiet);
    calm = quiet;
    repeat (n) begin
      if ($urandom_range(99) < read_pct) send_read();
      else send_scan(pick_scancode());
    end
    calm = 1'b0;
  endtask

  // response side: random stalls, plus two long hold-offs so the pipeline
  // backs up and req.ready has to drop while requests keep coming
  initial begin : receiver
    int stall;
    int hold;
    int cycle;
    stall = 0;
    hold  = 0;
    cycle = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle == 700 || cycle == 3500) hold = 300;
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!calm && $urandom_range(99) < 25) stall = pick_gap();
      end
    end
  end

  // check every accepted response against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.char_valid, rsp_if.char_out, rsp_if.chars_waiting);
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sb = new(FIFO_DEPTH);
    calm = 1'b0;
    rst = 1'b1;
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_SCAN;
    req_if.scancode = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty read, table edges, keys with no character, breaks,
    // both shifts, prefix handling (single and repeated), reads draining
    send_read();
    send_scan(8'h02);            // '1'
    send_scan(8'h00);            // table hole at key 0
    send_scan(8'h3a);            // first code past the table
    send_scan(8'h7f);            // highest make code
    send_scan(8'h80);            // break of key 0
    send_scan(8'hff);
    send_scan(SC_LSHIFT_MAKE);
    send_scan(8'h10);            // 'Q'
    send_scan(8'h39);            // space, last table entry
    send_scan(SC_LSHIFT_BREAK);
    send_scan(SC_RSHIFT_MAKE);
    send_scan(8'h1e);            // 'A'
    send_scan(SC_RSHIFT_BREAK);
    send_scan(SC_PREFIX);
    send_scan(8'h1e);            // dropped after prefix
    send_scan(SC_PREFIX);
    send_scan(SC_PREFIX);        // prefix again keeps the flag set
    send_scan(8'h2a);            // dropped, so shift stays released
    send_scan(8'h1e);            // 'a'
    repeat (5) send_read();      // last one takes the final character, leaving the fifo empty

    // random: fill to full, drain, mixed traffic, calm stretches
    run_phase(300, 3, 1'b0);
    run_phase(200, 50, 1'b1);
    run_phase(250, 85, 1'b0);
    run_phase(400, 30, 1'b0);
    run_phase(200, 5, 1'b1);
    run_phase(400, 50, 1'b0);

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sc2a_pkg.sv
rtl/sc2a_if.sv
rtl/sc2a_ram.sv
rtl/sc2a_decode.sv
rtl/scancode_to_ascii_fifo_core.sv
test/tb_top.sv
